### sv/vdib_pkg.sv
package vdib_pkg;

	localparam int MAX_VERTICES = 256;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int WORDS        = 11;
	localparam int VTX_W        = WORDS * 32;
	localparam int OUT_IDX_W    = 8;

	// item kinds
	localparam logic [1:0] KIND_ADD     = 2'd0;
	localparam logic [1:0] KIND_ADD_NEW = 2'd1;
	localparam logic [1:0] KIND_CLEAR   = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] norm_x;
		logic [31:0] norm_y;
		logic [31:0] norm_z;
		logic [31:0] col_r;
		logic [31:0] col_g;
		logic [31:0] col_b;
		logic [31:0] tex_u;
		logic [31:0] tex_v;
	} vtx_word_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] vertex_index;
		logic                 is_new;
		logic                 store_full;
	} res_word_t;

	typedef enum logic [1:0] {
		RES_ZERO   = 2'd0,
		RES_HIT    = 2'd1,
		RES_APPEND = 2'd2,
		RES_CLEAR  = 2'd3
	} res_code_t;

	typedef struct packed {
		logic      capture;
		logic      step;
		logic      commit;
		res_code_t code;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       hit;
		logic       more;
		logic       out_free;
	} dp_sts_t;

	// low bits of a store index as the index-list value
	function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] idx);
		logic [IDX_W+OUT_IDX_W-1:0] ext;
		ext = {{OUT_IDX_W{1'b0}}, idx};
		return ext[OUT_IDX_W-1:0];
	endfunction

endpackage

### sv/vdib_ctrl.sv
module vdib_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vtx_valid,
	output logic             vtx_stall,
	input  vdib_pkg::dp_sts_t sts,
	output vdib_pkg::dp_cmd_t cmd
);
	import vdib_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	state_t    state_q, state_d;
	res_code_t code_q, code_d;

	always_comb begin
		state_d = state_q;
		code_d  = code_q;
		cmd     = '0;
		cmd.code = code_q;
		case (state_q)
			ST_IDLE: begin
				if (vtx_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				state_d = ST_RESULT;
				case (sts.kind)
					KIND_ADD: begin
						if (sts.hit) begin
							code_d = RES_HIT;
						end else if (sts.more) begin
							cmd.step = 1'b1;
							state_d  = ST_SEARCH;
						end else begin
							code_d = RES_APPEND;
						end
					end
					KIND_ADD_NEW: code_d = RES_APPEND;
					KIND_CLEAR:   code_d = RES_CLEAR;
					default:      code_d = RES_ZERO;
				endcase
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			code_q  <= RES_ZERO;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

	assign vtx_stall = (state_q != ST_IDLE);

endmodule

### sv/vdib_dpath.sv
module vdib_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  vdib_pkg::vtx_word_t vtx,
	input  vdib_pkg::dp_cmd_t   cmd,
	output vdib_pkg::dp_sts_t   sts,
	output logic                res_valid,
	input  logic                res_stall,
	output vdib_pkg::res_word_t res
);
	import vdib_pkg::*;

	logic [VTX_W-1:0] store_mem [MAX_VERTICES];

	logic [1:0]       kind_q;
	logic [VTX_W-1:0] vert_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic             rd_v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [VTX_W-1:0] rd_data_s1;
	logic             res_valid_q;
	res_word_t        res_q;
	res_word_t        res_d;
	logic             full;
	logic             wr_en;

	assign full  = (count_q >= CNT_W'(MAX_VERTICES));
	assign wr_en = cmd.commit && (cmd.code == RES_APPEND) && !full;

	// store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_mem[count_q[IDX_W-1:0]] <= vert_q;
		end
		rd_data_s1 <= store_mem[ptr_q[IDX_W-1:0]];
	end

	// captured vertex and search index
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			vert_q <= {vtx.pos_x, vtx.pos_y, vtx.pos_z, vtx.norm_x, vtx.norm_y,
				vtx.norm_z, vtx.col_r, vtx.col_g, vtx.col_b, vtx.tex_u, vtx.tex_v};
		end
		if (cmd.step) begin
			idx_s1 <= ptr_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_ADD;
			ptr_q   <= '0;
			rd_v_s1 <= 1'b0;
			count_q <= '0;
		end else begin
			if (cmd.capture) begin
				kind_q  <= vtx.kind;
				ptr_q   <= '0;
				rd_v_s1 <= 1'b0;
			end else begin
				rd_v_s1 <= cmd.step;
				if (cmd.step) begin
					ptr_q <= ptr_q + CNT_W'(1);
				end
			end
			if (cmd.commit) begin
				if (cmd.code == RES_CLEAR) begin
					count_q <= '0;
				end else if (wr_en) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	// result word for the current code
	always_comb begin
		res_d = '0;
		case (cmd.code)
			RES_HIT: res_d.vertex_index = out_index(idx_s1);
			RES_APPEND: begin
				if (full) begin
					res_d.store_full = 1'b1;
				end else begin
					res_d.vertex_index = out_index(count_q[IDX_W-1:0]);
					res_d.is_new       = 1'b1;
				end
			end
			default: res_d = '0;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign sts.kind     = kind_q;
	assign sts.hit      = rd_v_s1 && (rd_data_s1 == vert_q);
	assign sts.more     = (ptr_q < count_q);
	assign sts.out_free = !res_valid_q || !res_stall;

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### sv/vertex_dedup_index_builder_top.sv
// vertex dedup index builder: one vertex word in, one index word out
// add with dedup: stored entries compared one per cycle from the single-read-port store
// until a hit or the last entry, then the index word is registered and posted
// forced add, clear and unused kind: no scan; the index word is registered and posted
// next vertex word taken only once the index word is posted (vtx_stall held meanwhile,
// also through any index stall); reset clears the vertex count, store left undefined
module vertex_dedup_index_builder_top (
	input  logic                clk,
	input  logic                arst_n,
	// vertex channel
	input  logic                vtx_valid,
	output logic                vtx_stall,
	input  vdib_pkg::vtx_word_t vtx,
	// index channel
	output logic                res_valid,
	input  logic                res_stall,
	output vdib_pkg::res_word_t res
);
	import vdib_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencer: capture, scan the store, then post the result word
	vdib_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: vertex store, scan pointer, compare, vertex count and result register
	vdib_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx       (vtx),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
